// ===== sv/bit_reversed_des_block_encrypt_macros.svh =====
// assertion macros for the bit reversed des block encryptor
`ifndef BIT_REVERSED_DES_BLOCK_ENCRYPT_MACROS_SVH
`define BIT_REVERSED_DES_BLOCK_ENCRYPT_MACROS_SVH
`ifndef SYNTH
`define BRD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`define BRD_ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`else
`define BRD_ASSERT_NEXT(label, clk, rst, pre, post)
`define BRD_ASSERT_NOW(label, clk, rst, cond)
`endif
`endif

// ===== sv/brdes_pkg.sv =====
// constants, tables and round functions for the des encryptor
package brdes_pkg;

   localparam int NumRounds = 16;
   localparam int NumKeys   = 4;

   localparam logic [63:0] KEYS [NumKeys] = '{
      64'h779CCBFA5CB55B07, 64'hF0BBD789457A1ED7,
      64'h375CF0EC9E0FF660, 64'h3765FB6352B9C86A};

   localparam byte unsigned T_IP [64] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam byte unsigned T_FP [64] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam byte unsigned T_E [48] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam byte unsigned T_P [32] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam byte unsigned T_PC1 [56] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
      60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
      61,53,45,37,29,21,13,5,28,20,12,4};
   localparam byte unsigned T_PC2 [48] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   localparam byte unsigned T_SHIFT [NumRounds] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
   localparam byte unsigned T_SBOX [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   typedef struct packed {
      logic [31:0] l;
      logic [31:0] r;
      logic [1:0]  key_select;
      logic        last;
   } stage_type;

   function automatic logic [63:0] reverse64(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[i] = v[63 - i];
      return r;
   endfunction

   function automatic logic [63:0] perm_ip(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63 - i] = v[64 - int'(T_IP[i])];
      return r;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63 - i] = v[64 - int'(T_FP[i])];
      return r;
   endfunction

   // subkey of one round, all folded to constants at elaboration
   function automatic logic [47:0] subkey(input int k, input int rnd);
      logic [55:0] cd;
      logic [27:0] c;
      logic [27:0] d;
      logic [47:0] r;
      for (int i = 0; i < 56; i++) cd[55 - i] = KEYS[k][64 - int'(T_PC1[i])];
      c = cd[55:28];
      d = cd[27:0];
      for (int j = 0; j <= rnd; j++) begin
         for (int s = 0; s < int'(T_SHIFT[j]); s++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
      end
      cd = {c, d};
      for (int i = 0; i < 48; i++) r[47 - i] = cd[56 - int'(T_PC2[i])];
      return r;
   endfunction

   function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  b;
      for (int i = 0; i < 48; i++) x[47 - i] = r[32 - int'(T_E[i])];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         b = x[47 - 6 * i -: 6];
         s[31 - 4 * i -: 4] = T_SBOX[i][{b[5], b[0], b[4:1]}][3:0];
      end
      for (int i = 0; i < 32; i++) p[31 - i] = s[32 - int'(T_P[i])];
      return p;
   endfunction

endpackage

// ===== sv/brdes_round.sv =====
// one registered des round with constant subkeys for each fixed key
module brdes_round
   import brdes_pkg::*;
#(
   parameter int Round = 0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  stage_type stage_in,
   output logic      valid_out,
   output stage_type stage_out
);
   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in_c;
   logic [47:0] key_c;

   always_comb begin
      case (stage_in.key_select)
         2'd0:    key_c = subkey(0, Round);
         2'd1:    key_c = subkey(1, Round);
         2'd2:    key_c = subkey(2, Round);
         default: key_c = subkey(3, Round);
      endcase
      stage_in_c            = stage_in;
      stage_in_c.l          = stage_in.r;
      stage_in_c.r          = stage_in.l ^ round_f(stage_in.r, key_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         stage_ff <= stage_in_c;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;
endmodule

// ===== sv/bit_reversed_des_block_encrypt.sv =====
// top level of the bit reversed des block encryptor
// usage:
//   requests enter on req_valid/req_ready with req_key_select, req_data_block
//   and req_last_block; results leave on rsp_valid/rsp_ready with
//   rsp_cipher_block and rsp_last_out, one result per request, in order.
//   the block is bit reversed, encrypted with single des under one of four
//   fixed keys, and bit reversed again.
// path: the accepting edge loads an input register that also does the initial
//   permutation, then one register per des round follows.
// throughput: one request per cycle unless stalled; the sixteen round stages set the depth.
// stall: the whole pipeline holds while the output stage is full and
//   rsp_ready is low; req_ready is low only then, and nothing is lost.
// reset: synchronous, clears all stage valid bits; payload is not reset.
module bit_reversed_des_block_encrypt
   import brdes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_key_select,
   input  logic [63:0] req_data_block,
   input  logic        req_last_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cipher_block,
   output logic        rsp_last_out
);
`include "bit_reversed_des_block_encrypt_macros.svh"

   logic      advance;
   logic      in_valid_ff;
   stage_type in_stage_ff;
   stage_type in_stage_in;
   logic [63:0] ip_c;
   logic      valid_w [NumRounds + 1];
   stage_type stage_w [NumRounds + 1];

   // pipeline moves unless the last stage holds an untaken result
   assign advance   = !valid_w[NumRounds] || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      ip_c                   = perm_ip(reverse64(req_data_block));
      in_stage_in.l          = ip_c[63:32];
      in_stage_in.r          = ip_c[31:0];
      in_stage_in.key_select = req_key_select;
      in_stage_in.last       = req_last_block;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         in_stage_ff <= in_stage_in;
      end
   end

   assign valid_w[0] = in_valid_ff;
   assign stage_w[0] = in_stage_ff;

   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      brdes_round #(.Round(g)) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (valid_w[g]),
         .stage_in  (stage_w[g]),
         .valid_out (valid_w[g + 1]),
         .stage_out (stage_w[g + 1])
      );
   end

   // final swap undone, then final permutation and reversal
   assign rsp_valid        = valid_w[NumRounds];
   assign rsp_cipher_block =
      reverse64(perm_fp({stage_w[NumRounds].r, stage_w[NumRounds].l}));
   assign rsp_last_out     = stage_w[NumRounds].last;

   `BRD_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cipher_block))
   `BRD_ASSERT_NOW(a_ready, clock, reset, req_ready == (!rsp_valid || rsp_ready))
   `BRD_ASSERT_NEXT(a_enter, clock, reset, req_valid && req_ready, in_valid_ff)
endmodule

// ===== tb/tb.sv =====
// testbench for the bit reversed des block encryptor
`timescale 1ns / 1ps

class cipher_scoreboard;
   logic [63:0] exp_cipher [$];
   logic        exp_last [$];
   int          errors;

   static function logic [63:0] flip64(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[i] = v[63 - i];
      return r;
   endfunction

   static function logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] p;
      logic [5:0]  b;
      logic [7:0]  sv;
      for (int i = 0; i < 48; i++) x[47 - i] = r[32 - int'(brdes_pkg::T_E[i])];
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         b = x[47 - 6 * i -: 6];
         sv = brdes_pkg::T_SBOX[i][{b[5], b[0]} * 16 + b[4:1]];
         s[31 - 4 * i -: 4] = sv[3:0];
      end
      for (int i = 0; i < 32; i++) p[31 - i] = s[32 - int'(brdes_pkg::T_P[i])];
      return p;
   endfunction

   static function logic [63:0] des_enc(input logic [63:0] blk, input logic [63:0] key);
      logic [55:0] cd;
      logic [27:0] c;
      logic [27:0] d;
      logic [47:0] k;
      logic [63:0] v;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] t;
      logic [63:0] o;
      for (int i = 0; i < 56; i++) cd[55 - i] = key[64 - int'(brdes_pkg::T_PC1[i])];
      c = cd[55:28];
      d = cd[27:0];
      for (int i = 0; i < 64; i++) v[63 - i] = blk[64 - int'(brdes_pkg::T_IP[i])];
      l = v[63:32];
      r = v[31:0];
      for (int n = 0; n < 16; n++) begin
         for (int s = 0; s < int'(brdes_pkg::T_SHIFT[n]); s++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
         cd = {c, d};
         for (int i = 0; i < 48; i++) k[47 - i] = cd[56 - int'(brdes_pkg::T_PC2[i])];
         t = l ^ feistel(r, k);
         l = r;
         r = t;
      end
      v = {r, l};
      for (int i = 0; i < 64; i++) o[63 - i] = v[64 - int'(brdes_pkg::T_FP[i])];
      return o;
   endfunction

   function void note_request(input logic [1:0] ks, input logic [63:0] data, input logic last);
      exp_cipher.push_back(flip64(des_enc(flip64(data), brdes_pkg::KEYS[ks])));
      exp_last.push_back(last);
   endfunction

   function void check_result(input logic [63:0] cipher, input logic last);
      logic [63:0] ec;
      logic        el;
      if (exp_cipher.size() == 0) begin
         $error("unexpected result cipher_block=%h", cipher);
         errors++;
         return;
      end
      ec = exp_cipher.pop_front();
      el = exp_last.pop_front();
      if (cipher !== ec) begin
         $error("cipher_block expected %h actual %h", ec, cipher);
         errors++;
      end
      if (last !== el) begin
         $error("last_out expected %b actual %b", el, last);
         errors++;
      end
   endfunction
endclass

module tb;
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_key_select;
   logic [63:0] req_data_block;
   logic        req_last_block;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_cipher_block;
   logic        rsp_last_out;

   cipher_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;

   bit_reversed_des_block_encrypt uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   // receiver: sample on rising edge, change ready on falling edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_cipher_block, rsp_last_out);
   end

   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_request(input logic [1:0] ks, input logic [63:0] data, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_key_select <= ks;
      req_data_block <= data;
      req_last_block <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_request(ks, data, last);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.exp_cipher.size() != 0) @(negedge clock);
   endtask

   task automatic random_phase(input int n);
      logic [63:0] d;
      for (int i = 0; i < n; i++) begin
         d = {$urandom, $urandom};
         case ($urandom_range(3))
            0: d = {8{8'($urandom)}};
            1: d = d & {$urandom, $urandom};
            default: ;
         endcase
         send_request(2'($urandom_range(3)), d, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      logic [63:0] pat [6];
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_key_select = '0;
      req_data_block = '0;
      req_last_block = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      pat = '{64'h0, 64'hFFFFFFFFFFFFFFFF, 64'h8000000000000001, 64'h0123456789ABCDEF,
              64'hAAAAAAAA55555555, 64'h0000000000000001};
      // every key against corner patterns
      for (int k = 0; k < 4; k++)
         for (int p = 0; p < 6; p++) send_request(2'(k), pat[p], 1'((k + p) % 2));
      drain();

      random_phase(250);
      send_idle_pct = 58;
      random_phase(250);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 58;
      random_phase(250);
      send_idle_pct = 14;
      recv_stall_pct = 14;
      random_phase(250);
      drain();
      repeat (20) @(negedge clock);

      if (sb.errors == 0 && sb.exp_cipher.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
